[sv/gbsp_pkg.sv]
// Shared types and constants of the graph bisection swap pass.
`default_nettype none
package gbsp_pkg;

  localparam int ROW_W    = 64;
  localparam int VIDX_W   = 6;
  localparam int VC_W     = 7;
  localparam int DEF_W    = 9;
  localparam int GAIN_W   = 12;
  localparam int SGAIN_W  = 7;
  localparam int CUT_W    = 11;
  localparam int CACC_W   = 12;
  localparam int SWAPS_W  = 6;
  localparam int POP_W    = 7;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 112;

  localparam logic [GAIN_W-1:0]  GAIN_CAP      = 12'd2048;
  localparam logic [SGAIN_W-1:0] SWAP_GAIN_CAP = 7'd127;
  localparam logic [SWAPS_W:0]   MAX_SWAPS     = 7'd32;
  localparam logic [VC_W-1:0]    VC_RESET      = 7'd64;

  localparam logic              ACT_LOAD = 1'b0;
  localparam logic              ACT_RUN  = 1'b1;
  localparam logic [PADDR_W-1:0] ADDR_VERTEX_COUNT = 3'd0;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DEF   = 9'b000000010,
    S_SEL   = 9'b000000100,
    S_EDGE  = 9'b000001000,
    S_GAIN  = 9'b000010000,
    S_EMIT  = 9'b000100000,
    S_UPD   = 9'b001000000,
    S_CUT   = 9'b010000000,
    S_FINAL = 9'b100000000
  } state_t;

  typedef struct packed {
    logic [VIDX_W-1:0]  vertex_a;
    logic [VIDX_W-1:0]  vertex_b;
    logic [SGAIN_W-1:0] swap_gain;
    logic [GAIN_W-1:0]  running_gain;
    logic [CUT_W-1:0]   cut_edges;
    logic [ROW_W-1:0]   side_map;
    logic               last;
  } result_t;

endpackage
`default_nettype wire

[sv/gbsp_count.sv]
// Shared bit-count unit: neighbors in a selected set and all neighbors of one row.
`default_nettype none
module gbsp_count (
  input  wire logic [gbsp_pkg::ROW_W-1:0] word,
  input  wire logic [gbsp_pkg::ROW_W-1:0] sel,
  output logic      [gbsp_pkg::POP_W-1:0] ext,
  output logic      [gbsp_pkg::POP_W-1:0] tot
);

  function automatic logic [3:0] pop8(input logic [7:0] b);
    logic [3:0] c;
    c = '0;
    for (int k = 0; k < 8; k++) begin
      c = c + 4'(b[k]);
    end
    return c;
  endfunction

  function automatic logic [gbsp_pkg::POP_W-1:0] pop64(input logic [63:0] w);
    logic [4:0] q0, q1, q2, q3;
    q0 = 5'(pop8(w[7:0]))   + 5'(pop8(w[15:8]));
    q1 = 5'(pop8(w[23:16])) + 5'(pop8(w[31:24]));
    q2 = 5'(pop8(w[39:32])) + 5'(pop8(w[47:40]));
    q3 = 5'(pop8(w[55:48])) + 5'(pop8(w[63:56]));
    return (7'(q0) + 7'(q1)) + (7'(q2) + 7'(q3));
  endfunction

  assign ext = pop64(word & sel);
  assign tot = pop64(word);

endmodule
`default_nettype wire

[sv/gbsp_core.sv]
// Sequencer, row and deficit memories of the swap pass around the shared count unit.
`default_nettype none
module gbsp_core #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_action,
  input  wire logic [gbsp_pkg::VIDX_W-1:0]   in_vertex,
  input  wire logic [gbsp_pkg::ROW_W-1:0]    in_row,
  input  wire logic                          in_side,
  input  wire logic [gbsp_pkg::VC_W-1:0]     vertex_count,
  input  wire logic                          res_ready,
  output logic                               res_valid,
  output gbsp_pkg::result_t                  res
);

  localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = IW + 1;
  localparam int DW = gbsp_pkg::DEF_W;

  gbsp_pkg::state_t state;

  logic [gbsp_pkg::ROW_W-1:0] adj_mem [MAX_VERTICES];
  logic [DW-1:0]              def_mem [MAX_VERTICES];
  logic [gbsp_pkg::ROW_W-1:0] adj_q;
  logic signed [DW-1:0]       def_q;

  logic [MAX_VERTICES-1:0]        side_bits;
  logic [MAX_VERTICES-1:0]        locked;
  logic [gbsp_pkg::GAIN_W-1:0]    gain_total;
  logic [gbsp_pkg::SWAPS_W:0]     swaps;
  logic [CW-1:0]                  cnt;
  logic                           p_v;
  logic [IW-1:0]                  p_i;
  logic [IW-1:0]                  best_a, best_b;
  logic signed [DW-1:0]           def_a, def_b;
  logic                           fa, fb;
  logic [gbsp_pkg::SGAIN_W-1:0]   g_r;
  logic [gbsp_pkg::CACC_W-1:0]    cut_acc;

  logic [gbsp_pkg::VC_W-1:0]  n7;
  logic [CW-1:0]              n;
  logic [gbsp_pkg::ROW_W-1:0] mask, row_m, sel, sv;
  logic [gbsp_pkg::POP_W-1:0] ext, tot;
  logic [IW-1:0]              rd_addr;
  logic                       load_acc, run_acc, sweep_done, side_p;
  logic signed [DW-1:0]       def_new, upd_new;
  logic signed [DW:0]         g;
  logic [gbsp_pkg::GAIN_W:0]  gsum;

  assign n7 = (vertex_count > gbsp_pkg::VC_W'(MAX_VERTICES)) ?
              gbsp_pkg::VC_W'(MAX_VERTICES) : vertex_count;
  assign n  = n7[CW-1:0];

  always_comb begin
    for (int k = 0; k < gbsp_pkg::ROW_W; k++) begin
      mask[k] = (gbsp_pkg::VC_W'(k) < n7);
    end
  end

  assign in_ready = (state == gbsp_pkg::S_IDLE);
  assign load_acc = in_valid && in_ready && (in_action == gbsp_pkg::ACT_LOAD);
  assign run_acc  = in_valid && in_ready && (in_action == gbsp_pkg::ACT_RUN);

  assign rd_addr    = (state == gbsp_pkg::S_EDGE) ? best_a : cnt[IW-1:0];
  assign sweep_done = (cnt == n) && !p_v;

  // Row of the vertex in the processing slot, with the diagonal and unused columns removed.
  assign sv     = gbsp_pkg::ROW_W'(side_bits);
  assign side_p = side_bits[p_i];
  assign row_m  = adj_q & mask & ~(gbsp_pkg::ROW_W'(1) << p_i);
  always_comb begin
    if (state == gbsp_pkg::S_CUT) begin
      sel = side_p ? ~sv : sv;
    end else begin
      sel = side_p ? sv : ~sv;
    end
  end

  gbsp_count u_count (
    .word (row_m),
    .sel  (sel),
    .ext  (ext),
    .tot  (tot)
  );

  assign def_new = $signed({1'b0, ext, 1'b0}) - $signed({2'b00, tot});

  always_comb begin
    logic plus, minus;
    plus    = side_p ? adj_q[best_b] : adj_q[best_a];
    minus   = side_p ? adj_q[best_a] : adj_q[best_b];
    upd_new = def_q + (plus ? DW'(2) : DW'(0)) - (minus ? DW'(2) : DW'(0));
  end

  assign g    = (DW+1)'(def_a) + (DW+1)'(def_b) - (adj_q[best_b] ? (DW+1)'(2) : (DW+1)'(0));
  assign gsum = (gbsp_pkg::GAIN_W+1)'(gain_total) + (gbsp_pkg::GAIN_W+1)'(g[DW-1:0]);

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (load_acc && ({1'b0, in_vertex} < gbsp_pkg::VC_W'(MAX_VERTICES))) begin
      adj_mem[in_vertex[IW-1:0]] <= in_row;
    end
    adj_q <= adj_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (p_v && (state == gbsp_pkg::S_DEF)) begin
      def_mem[p_i] <= def_new;
    end else if (p_v && (state == gbsp_pkg::S_UPD) && !locked[p_i]) begin
      def_mem[p_i] <= upd_new;
    end
    def_q <= def_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gbsp_pkg::S_IDLE;
      side_bits  <= '0;
      locked     <= '0;
      gain_total <= '0;
      swaps      <= '0;
      cnt        <= '0;
      p_v        <= 1'b0;
      fa         <= 1'b0;
      fb         <= 1'b0;
      cut_acc    <= '0;
    end else begin
      p_i <= cnt[IW-1:0];
      if (cnt < n) begin
        cnt <= cnt + CW'(1);
      end
      p_v <= (cnt < n);
      unique case (state)
        gbsp_pkg::S_IDLE: begin
          cnt <= '0;
          p_v <= 1'b0;
          if (load_acc && ({1'b0, in_vertex} < gbsp_pkg::VC_W'(MAX_VERTICES))) begin
            side_bits[in_vertex[IW-1:0]] <= in_side;
          end
          if (run_acc) begin
            locked <= '0;
            swaps  <= '0;
            state  <= gbsp_pkg::S_DEF;
          end
        end
        gbsp_pkg::S_DEF: begin
          if (sweep_done) begin
            cnt   <= '0;
            p_v   <= 1'b0;
            fa    <= 1'b0;
            fb    <= 1'b0;
            state <= gbsp_pkg::S_SEL;
          end
        end
        gbsp_pkg::S_SEL: begin
          if (p_v && !locked[p_i]) begin
            if (!side_p) begin
              if (!fa || (def_q > def_a)) begin
                fa     <= 1'b1;
                best_a <= p_i;
                def_a  <= def_q;
              end
            end else begin
              if (!fb || (def_q > def_b)) begin
                fb     <= 1'b1;
                best_b <= p_i;
                def_b  <= def_q;
              end
            end
          end
          if (sweep_done) begin
            cnt     <= '0;
            p_v     <= 1'b0;
            cut_acc <= '0;
            state   <= (fa && fb) ? gbsp_pkg::S_EDGE : gbsp_pkg::S_CUT;
          end
        end
        gbsp_pkg::S_EDGE: begin
          state <= gbsp_pkg::S_GAIN;
        end
        gbsp_pkg::S_GAIN: begin
          cnt <= '0;
          p_v <= 1'b0;
          if (g > 0) begin
            locked[best_a]    <= 1'b1;
            locked[best_b]    <= 1'b1;
            side_bits[best_a] <= ~side_bits[best_a];
            side_bits[best_b] <= ~side_bits[best_b];
            gain_total <= (gsum > (gbsp_pkg::GAIN_W+1)'(gbsp_pkg::GAIN_CAP)) ?
                          gbsp_pkg::GAIN_CAP : gsum[gbsp_pkg::GAIN_W-1:0];
            g_r   <= (g > (DW+1)'(gbsp_pkg::SWAP_GAIN_CAP)) ?
                     gbsp_pkg::SWAP_GAIN_CAP : g[gbsp_pkg::SGAIN_W-1:0];
            state <= gbsp_pkg::S_EMIT;
          end else begin
            cut_acc <= '0;
            state   <= gbsp_pkg::S_CUT;
          end
        end
        gbsp_pkg::S_EMIT: begin
          cnt <= '0;
          p_v <= 1'b0;
          if (res_ready) begin
            state <= gbsp_pkg::S_UPD;
          end
        end
        gbsp_pkg::S_UPD: begin
          if (sweep_done) begin
            cnt     <= '0;
            p_v     <= 1'b0;
            fa      <= 1'b0;
            fb      <= 1'b0;
            cut_acc <= '0;
            swaps   <= swaps + 1'b1;
            state   <= ((swaps + 1'b1) == gbsp_pkg::MAX_SWAPS) ?
                       gbsp_pkg::S_CUT : gbsp_pkg::S_SEL;
          end
        end
        gbsp_pkg::S_CUT: begin
          if (p_v) begin
            cut_acc <= cut_acc + gbsp_pkg::CACC_W'(ext);
          end
          if (sweep_done) begin
            state <= gbsp_pkg::S_FINAL;
          end
        end
        gbsp_pkg::S_FINAL: begin
          cnt <= '0;
          p_v <= 1'b0;
          if (res_ready) begin
            state <= gbsp_pkg::S_IDLE;
          end
        end
        default: begin
          state <= gbsp_pkg::S_IDLE;
        end
      endcase
    end
  end

  assign res_valid = ((state == gbsp_pkg::S_EMIT) || (state == gbsp_pkg::S_FINAL)) && res_ready;

  always_comb begin
    res              = '0;
    res.running_gain = gain_total;
    if (state == gbsp_pkg::S_FINAL) begin
      res.cut_edges = cut_acc[gbsp_pkg::CACC_W-1:1];
      res.side_map  = sv;
      res.last      = 1'b1;
    end else begin
      res.vertex_a  = gbsp_pkg::VIDX_W'(best_a);
      res.vertex_b  = gbsp_pkg::VIDX_W'(best_b);
      res.swap_gain = g_r;
    end
  end

  a_res_slot: assert property (@(posedge clk) disable iff (rst) res_valid |-> res_ready)
    else $error("result issued while the output slot is full");
  a_lock_stable: assert property (@(posedge clk) disable iff (rst)
    (state == gbsp_pkg::S_UPD) && $past(state == gbsp_pkg::S_UPD) |-> $stable(locked))
    else $error("lock set changed during the deficit update sweep");
  a_lock_pairs: assert property (@(posedge clk) disable iff (rst)
    ($countones(locked) % 2) == 0)
    else $error("vertices were locked outside of pairs");
  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.last |=> state == gbsp_pkg::S_IDLE)
    else $error("pass did not end after the final result");
  a_swap_bound: assert property (@(posedge clk) disable iff (rst)
    swaps <= gbsp_pkg::MAX_SWAPS)
    else $error("too many swaps in one pass");

endmodule
`default_nettype wire

[sv/graph_bisection_swap_pass.sv]
// Top level of the graph bisection swap pass: stream ports, register port, output slot.
//
// Input stream (s_*): s_tuser selects the action. A load transaction (tuser 0) writes one
// adjacency row and the side of one vertex. A run transaction (tuser 1)
// starts one greedy swap pass over the first vertex_count vertices.
// A pass first sweeps the deficits, then per swap round runs a selection sweep, a row
// read for the pair edge, the gain, the result and an update sweep, one row each cycle
// through the registered memory read ports, then sweeps the cut. s_tready is low for the
// whole pass.
// Output stream (m_*): one transaction per accepted swap and a final transaction with
// m_tlast high carrying the side map and cut size. A single output register holds the
// result; while the receiver stalls the pass waits before issuing the next result.
// Register port: vertex_count at byte address 0, to be written by the user only while the
// block is idle (not enforced). Reset (rst, synchronous) clears the side map, lock set and
// gain total and sets vertex_count to 64; adjacency rows are undefined until loaded.
`default_nettype none
module graph_bisection_swap_pass #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // vertex[5:0], adjacency_row[69:6], side[70], zero pad
  input  wire logic [gbsp_pkg::IN_DATA_W-1:0]    s_tdata,
  // action
  input  wire logic                              s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // vertex_a[5:0], vertex_b[11:6], swap_gain[18:12], running_gain[30:19],
  // cut_edges[41:31], side_map[105:42], zero pad
  output logic      [gbsp_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                                   m_tlast,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [gbsp_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [gbsp_pkg::PDATA_W-1:0]      pwdata,
  output logic      [gbsp_pkg::PDATA_W-1:0]      prdata,
  output logic                                   pready
);

  logic [gbsp_pkg::VC_W-1:0] vertex_count;
  logic                      res_ready, res_valid;
  gbsp_pkg::result_t         res;

  assign pready = 1'b1;
  assign prdata = (paddr == gbsp_pkg::ADDR_VERTEX_COUNT) ?
                  gbsp_pkg::PDATA_W'(vertex_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= gbsp_pkg::VC_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == gbsp_pkg::ADDR_VERTEX_COUNT)) begin
      vertex_count <= pwdata[gbsp_pkg::VC_W-1:0];
    end
  end

  gbsp_core #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_action    (s_tuser),
    .in_vertex    (s_tdata[5:0]),
    .in_row       (s_tdata[69:6]),
    .in_side      (s_tdata[70]),
    .vertex_count (vertex_count),
    .res_ready    (res_ready),
    .res_valid    (res_valid),
    .res          (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= {6'b0, res.side_map, res.cut_edges, res.running_gain, res.swap_gain,
                  res.vertex_b, res.vertex_a};
      m_tlast <= res.last;
    end
  end

endmodule
`default_nettype wire
